### rtl/epr_pkg.sv
`default_nettype none

package epr_pkg;

    localparam int INPUT_W    = 16;
    localparam int CAP_WIDE_W = 32;
    localparam int RANGE_W    = 14;
    localparam int PERIOD_W   = 8;
    localparam int COUNT_W    = 9;
    localparam int POS_W      = 8;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [0:0] {
        REG_RANGE_LIMIT    = 1'b0,
        REG_ABSENCE_PERIOD = 1'b1
    } cfg_reg_t;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd3;

    // width*17 of any in-range reading stays below 100*16384, so 21 bits
    localparam int                 PROD_W       = 21;
    localparam logic [PROD_W-1:0]  THRESH_SCALE = 21'd100;
    // (500 + 1) * 100
    localparam logic [PROD_W-1:0]  THRESH_RESET = 21'd50100;

    // floor(x/100) = (x * ceil(2^28/100)) >> 28 for x < 2^21
    localparam int                     DIST_RECIP_W = 22;
    localparam logic [DIST_RECIP_W-1:0] DIST_RECIP  = 22'd2684355;
    localparam int                     DIST_SHIFT   = 28;

    // floor(y/100) = (y * ceil(2^22/100)) >> 22 for y < 2^15
    localparam int                     POS_PROD_W  = 15;
    localparam int                     POS_RECIP_W = 16;
    localparam logic [POS_RECIP_W-1:0] POS_RECIP   = 16'd41944;
    localparam int                     POS_SHIFT   = 22;
    // first range whose scaled position passes 255
    localparam logic [RANGE_W-1:0]     POS_SAT_RANGE = 14'd1220;
    localparam logic [POS_W-1:0]       POS_MAX       = 8'd255;

    typedef struct packed {
        logic               done;
        logic [RANGE_W-1:0] range;
        logic               far;
        logic               present;
    } status_t;

endpackage

`default_nettype wire

### rtl/echo_pulse_range_with_presence.sv
// echo pulse range meter with hand-presence tracking
//
// input channel: in_valid / in_stall carry capture_value, the timer count
// latched at each echo edge; captures alternate rising, falling, rising...
// output channel: out_valid / out_stall carry one result per capture:
// measurement_done, range_value, out_of_range, hand_present, position_byte
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 is range_limit, index 1 is absence_period; cfg_ready is always
// high, and writes are expected only while no item is in flight
//
// three register stages: edge pairing and pulse width, distance and
// presence, position scaling; each accepted item passes through them in
// order, and one item per cycle is taken while out_stall is low
// out_stall holds the output register and backs up the stages behind it;
// in_stall rises only when all three stages are full and the output stalls
// reset: next capture is a rising edge, width and range zero, hand present,
// range_limit 500, absence_period 3, no result pending
`default_nettype none

module echo_pulse_range_with_presence
    import epr_pkg::*;
#(
    parameter int CAPTURE_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [INPUT_W-1:0]    capture_value,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       measurement_done,
    output logic [RANGE_W-1:0]         range_value,
    output logic                       out_of_range,
    output logic                       hand_present,
    output logic [POS_W-1:0]           position_byte,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int X_W   = CAPTURE_BITS + 5;
    localparam int CMP_W = (X_W > PROD_W) ? X_W : PROD_W;
    localparam logic [CAPTURE_BITS-1:0] CAP_MAX = '1;

    // pipeline control
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic en0;
    logic en1;
    logic en2;
    logic in_accept;
    logic s1_move;
    logic s2_move;

    assign en2       = !out_valid_reg || !out_stall;
    assign en1       = !s1_valid_reg || en2;
    assign en0       = !s0_valid_reg || en1;
    assign in_stall  = !en0;
    assign in_accept = in_valid && en0;
    assign s1_move   = s0_valid_reg && en1;
    assign s2_move   = s1_valid_reg && en2;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    // configuration
    logic [PROD_W-1:0]   thresh_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PROD_W-1:0]   thresh_next;

    // limit L accepted while floor(w*17/100) <= L, i.e. w*17 < (L+1)*100
    assign thresh_next = PROD_W'((PROD_W'(cfg_data) + PROD_W'(1)) * THRESH_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RANGE_LIMIT:
                begin
                    thresh_reg <= thresh_next;
                end
                REG_ABSENCE_PERIOD:
                begin
                    period_reg <= cfg_data[PERIOD_W-1:0];
                end
                default:
                begin
                    thresh_reg <= thresh_reg;
                end
            endcase
        end
    end

    // stage 0: edge pairing and pulse width
    logic [CAP_WIDE_W-1:0]   cap_wide;
    logic [CAPTURE_BITS-1:0] cap;
    logic                    awaiting_reg;
    logic [CAPTURE_BITS-1:0] rising_reg;
    logic [CAPTURE_BITS-1:0] width_reg;
    logic [CAPTURE_BITS-1:0] width_next;
    logic                    s0_done_reg;
    logic [CAPTURE_BITS-1:0] s0_width_reg;

    assign cap_wide = {{(CAP_WIDE_W-INPUT_W){1'b0}}, capture_value};
    assign cap      = cap_wide[CAPTURE_BITS-1:0];

    always_comb
    begin
        if (cap > rising_reg)
        begin
            width_next = cap - rising_reg;
        end
        else if (cap < rising_reg)
        begin
            width_next = (CAP_MAX - rising_reg) + cap;
        end
        else
        begin
            width_next = width_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            rising_reg   <= '0;
            width_reg    <= '0;
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                s0_valid_reg <= in_valid;
            end
            if (in_accept)
            begin
                awaiting_reg <= !awaiting_reg;
                if (!awaiting_reg)
                begin
                    rising_reg <= cap;
                end
                else
                begin
                    width_reg <= width_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_done_reg  <= awaiting_reg;
            s0_width_reg <= awaiting_reg ? width_next : width_reg;
        end
    end

    // stage 1: distance, limit check, presence
    logic [X_W-1:0]                 width_x17;
    logic [CMP_W-1:0]               x_cmp;
    logic [CMP_W-1:0]               thresh_cmp;
    logic                           in_range;
    logic [PROD_W+DIST_RECIP_W-1:0] dist_prod;
    logic [RANGE_W-1:0]             dist_val;

    assign width_x17  = ({5'b0, s0_width_reg} << 4) + {5'b0, s0_width_reg};
    assign x_cmp      = CMP_W'(width_x17);
    assign thresh_cmp = CMP_W'(thresh_reg);
    assign in_range   = x_cmp < thresh_cmp;
    assign dist_prod  = {{DIST_RECIP_W{1'b0}}, x_cmp[PROD_W-1:0]}
                      * {{PROD_W{1'b0}}, DIST_RECIP};
    assign dist_val   = dist_prod[DIST_SHIFT +: RANGE_W];

    logic                far_reg;
    logic [RANGE_W-1:0]  good_reg;
    logic [RANGE_W-1:0]  cur_reg;
    logic [COUNT_W-1:0]  absence_reg;
    logic                present_reg;
    logic                far_next;
    logic [RANGE_W-1:0]  good_next;
    logic [RANGE_W-1:0]  cur_next;
    logic [COUNT_W-1:0]  absence_next;
    logic                present_next;
    logic [COUNT_W:0]    absence_inc;
    logic [COUNT_W:0]    absence_cap;
    logic [COUNT_W:0]    absence_sat;
    status_t             s1_status_reg;

    assign absence_inc = {1'b0, absence_reg} + (COUNT_W+1)'(1);
    assign absence_cap = {2'b0, period_reg} + (COUNT_W+1)'(1);
    assign absence_sat = (absence_inc > absence_cap) ? absence_cap : absence_inc;

    always_comb
    begin
        far_next     = far_reg;
        good_next    = good_reg;
        cur_next     = cur_reg;
        absence_next = '0;
        present_next = 1'b1;
        if (s0_done_reg)
        begin
            if (in_range)
            begin
                far_next  = 1'b0;
                good_next = dist_val;
                cur_next  = dist_val;
            end
            else
            begin
                far_next = 1'b1;
                cur_next = good_reg;
            end
        end
        if (far_next)
        begin
            absence_next = absence_sat[COUNT_W-1:0];
            present_next = present_reg && !(absence_sat > {2'b0, period_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg      <= 1'b0;
            good_reg     <= '0;
            cur_reg      <= '0;
            absence_reg  <= '0;
            present_reg  <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s1_move)
            begin
                far_reg     <= far_next;
                good_reg    <= good_next;
                cur_reg     <= cur_next;
                absence_reg <= absence_next;
                present_reg <= present_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s1_status_reg <= '{done: s0_done_reg, range: cur_next,
                               far: far_next, present: present_next};
        end
    end

    // stage 2: position byte
    logic [POS_PROD_W-1:0]             range_x21;
    logic [POS_PROD_W+POS_RECIP_W-1:0] pos_prod;
    logic [POS_W-1:0]                  pos_next;
    logic                              done_reg;
    logic [RANGE_W-1:0]                range_reg;
    logic                              far_out_reg;
    logic                              present_out_reg;
    logic [POS_W-1:0]                  pos_reg;

    // wraps only above the saturation point, where it is not used
    assign range_x21 = ({1'b0, s1_status_reg.range} << 4)
                     + ({1'b0, s1_status_reg.range} << 2)
                     + {1'b0, s1_status_reg.range};
    assign pos_prod  = {{POS_RECIP_W{1'b0}}, range_x21}
                     * {{POS_PROD_W{1'b0}}, POS_RECIP};
    assign pos_next  = (s1_status_reg.range < POS_SAT_RANGE)
                     ? pos_prod[POS_SHIFT +: POS_W] : POS_MAX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            done_reg        <= s1_status_reg.done;
            range_reg       <= s1_status_reg.range;
            far_out_reg     <= s1_status_reg.far;
            present_out_reg <= s1_status_reg.present;
            pos_reg         <= pos_next;
        end
    end

    assign measurement_done = done_reg;
    assign range_value      = range_reg;
    assign out_of_range     = far_out_reg;
    assign hand_present     = present_out_reg;
    assign position_byte    = pos_reg;

`ifndef SYNTHESIS
    // the hand is only declared absent while readings are out of range
    absent_implies_far: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hand_present |-> out_of_range)
        else $error("hand absent on an in-range result");

    // large ranges saturate the position byte
    position_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (range_value >= POS_SAT_RANGE) |-> (position_byte == POS_MAX))
        else $error("position byte not saturated");

    // input backs up only when every stage is full and the output stalls
    stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall && s0_valid_reg && s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    // counter never passes one beyond the period it was clamped to
    absence_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && far_next |=> (absence_reg <= ($past(absence_cap[COUNT_W-1:0]))))
        else $error("absence count above its clamp");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import epr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic               done;
        logic [RANGE_W-1:0] range;
        logic               far;
        logic               present;
        logic [POS_W-1:0]   pos;
    } echo_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [INPUT_W-1:0]    capture_value;
    logic                  out_valid;
    logic                  out_stall;
    logic                  measurement_done;
    logic [RANGE_W-1:0]    range_value;
    logic                  out_of_range;
    logic                  hand_present;
    logic [POS_W-1:0]      position_byte;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic                  awaiting_fall;
    logic [INPUT_W-1:0]    rise_count;
    logic [INPUT_W-1:0]    width_count;
    logic [RANGE_W-1:0]    cur_range;
    logic [RANGE_W-1:0]    good_range;
    logic                  far_now;
    logic [COUNT_W-1:0]    absent_count;
    logic                  present_now;
    logic [RANGE_W-1:0]    limit_reg;
    logic [PERIOD_W-1:0]   period_reg;

    echo_result_t          pending_results[$];
    echo_result_t          seen_result;
    echo_result_t          want_result;
    int                    err_count;
    int                    quiet_cycles;
    int                    hold_req;
    bit                    idle_on;

    echo_pulse_range_with_presence #(
        .CAPTURE_BITS(16)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .capture_value    (capture_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .measurement_done (measurement_done),
        .range_value      (range_value),
        .out_of_range     (out_of_range),
        .hand_present     (hand_present),
        .position_byte    (position_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $display("mismatch %s: got %0d expected %0d", what, got, want);
        end
    endtask

    // works out the result of one accepted capture and queues it
    task automatic predict_echo(input logic [INPUT_W-1:0] cap);
        echo_result_t res;
        int unsigned  dist_val;
        int unsigned  pos;
        int unsigned  cap_cnt;
        int unsigned  nxt_cnt;
        res.done = 1'b0;
        if (!awaiting_fall)
        begin
            rise_count    = cap;
            awaiting_fall = 1'b1;
        end
        else
        begin
            if (cap > rise_count)
            begin
                width_count = cap - rise_count;
            end
            else if (cap < rise_count)
            begin
                width_count = 16'hffff - rise_count + cap;
            end
            dist_val = (int'(width_count) * 17) / 100;
            if (dist_val <= int'(limit_reg))
            begin
                far_now    = 1'b0;
                good_range = dist_val[RANGE_W-1:0];
                cur_range  = dist_val[RANGE_W-1:0];
            end
            else
            begin
                far_now   = 1'b1;
                cur_range = good_range;
            end
            awaiting_fall = 1'b0;
            res.done      = 1'b1;
        end
        if (far_now)
        begin
            cap_cnt      = int'(period_reg) + 1;
            nxt_cnt      = int'(absent_count) + 1;
            absent_count = (nxt_cnt > cap_cnt) ? cap_cnt[COUNT_W-1:0] : nxt_cnt[COUNT_W-1:0];
            if (absent_count > period_reg)
            begin
                present_now = 1'b0;
            end
        end
        else
        begin
            absent_count = '0;
            present_now  = 1'b1;
        end
        pos = (int'(cur_range) * 21) / 100;
        if (pos > 255)
        begin
            pos = 255;
        end
        res.range   = cur_range;
        res.far     = far_now;
        res.present = present_now;
        res.pos     = pos[POS_W-1:0];
        pending_results.push_back(res);
    endtask

    task automatic send_capture(input logic [INPUT_W-1:0] cap);
        int gap;
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        capture_value <= cap;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_echo(cap);
    endtask

    // stop offering items and let every queued result come out
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_RANGE_LIMIT)
        begin
            limit_reg = value[RANGE_W-1:0];
        end
        else
        begin
            period_reg = value[PERIOD_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic send_pair(input logic [INPUT_W-1:0] rise, input logic [INPUT_W-1:0] fall);
        send_capture(rise);
        send_capture(fall);
    endtask

    task automatic test_reset_values;
        send_pair(16'h0000, 16'h0000);               // equal counts, width still zero
        send_pair(16'h1000, 16'h1000 + 16'd2942);    // distance exactly at the limit
        send_pair(16'h1000, 16'h1000 + 16'd2948);    // one past the limit, held
        send_pair(16'h0000, 16'hffff);               // widest plain pulse
        send_pair(16'hffff, 16'h0000);               // wrap down to zero width
        send_pair(16'hffff, 16'hfffe);               // widest wrapped pulse
        send_pair(16'h5555, 16'haaaa);
        send_pair(16'haaaa, 16'h5555);               // hand goes absent here
        send_pair(16'd300, 16'd300);                 // equal counts keep the far width
        send_pair(16'd100, 16'd1100);                // near again, hand back
    endtask

    task automatic test_config_extremes;
        write_reg(REG_RANGE_LIMIT, 14'h3fff);
        write_reg(REG_ABSENCE_PERIOD, 14'd0);
        send_pair(16'h0000, 16'hffff);               // largest distance, position saturates
        send_pair(16'h0000, 16'd7177);               // first saturated position
        send_pair(16'h0000, 16'd7171);
        send_pair(16'h0000, 16'd6000);
        write_reg(REG_RANGE_LIMIT, 14'd0);
        send_pair(16'h0000, 16'd5);
        send_pair(16'h0000, 16'd6);                  // far, absent at once with period zero
        send_pair(16'h0000, 16'h0000);
    endtask

    task automatic test_period_lowered;
        write_reg(REG_ABSENCE_PERIOD, 14'd255);
        send_pair(16'h0000, 16'd5);
        repeat (6) send_pair(16'h0000, 16'd1000);
        write_reg(REG_ABSENCE_PERIOD, 14'd2);
        send_pair(16'h0000, 16'd1000);               // count clamps down, hand absent
        write_reg(REG_ABSENCE_PERIOD, 14'd255);
        send_pair(16'h0000, 16'd1000);               // stays absent until a near reading
    endtask

    task automatic test_random_pulses(input int n_items, input logic [RANGE_W-1:0] lim,
                                      input logic [PERIOD_W-1:0] per, input bit idle);
        int                 sent;
        int                 mode;
        int                 w;
        logic [INPUT_W-1:0] rise;
        write_reg(REG_RANGE_LIMIT, lim);
        write_reg(REG_ABSENCE_PERIOD, {6'd0, per});
        idle_on = idle;
        sent    = 0;
        while (sent < n_items)
        begin
            if (awaiting_fall)
            begin
                // realign after a stray edge
                send_capture(16'($urandom));
                sent++;
            end
            rise = 16'($urandom);
            mode = $urandom_range(0, 19);
            if (mode < 8)
            begin
                w = (int'(lim) * 100) / 17 + $urandom_range(0, 12) - 6;
                if (w < 0) w = 0;
                if (w > 65534) w = 65534;
                send_pair(rise, rise + 16'(w));
            end
            else if (mode < 12)
            begin
                send_pair(rise, rise + 16'($urandom_range(0, 3000)));
            end
            else if (mode < 14)
            begin
                send_pair(rise, rise);
            end
            else if (mode < 18)
            begin
                send_pair(rise, 16'($urandom));
            end
            else
            begin
                send_capture(rise);
                sent--;
            end
            sent += 2;
        end
        idle_on = 1'b1;
    endtask

    task automatic test_stall_fill;
        write_reg(REG_RANGE_LIMIT, 14'd2000);
        idle_on  = 1'b0;
        hold_req = 300;
        repeat (20) send_pair(16'($urandom), 16'($urandom));
        idle_on = 1'b1;
    endtask

    task automatic test_steady_flow;
        int k;
        write_reg(REG_RANGE_LIMIT, 14'd1500);
        write_reg(REG_ABSENCE_PERIOD, 14'd4);
        idle_on = 1'b0;
        for (k = 0; k < 100; k++)
        begin
            send_pair(16'($urandom), 16'($urandom));
        end
    endtask

    // receiver hold-off: random bursts, or one long stretch on request
    initial
    begin : stall_gen
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                stall_left = hold_req - 1;
                hold_req   = 0;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no item pending", 1, 0);
            end
            else
            begin
                want_result = pending_results.pop_front();
                seen_result = {measurement_done, range_value, out_of_range, hand_present,
                               position_byte};
                if (seen_result.done !== want_result.done)
                    report_mismatch("measurement_done", seen_result.done, want_result.done);
                if (seen_result.range !== want_result.range)
                    report_mismatch("range_value", seen_result.range, want_result.range);
                if (seen_result.far !== want_result.far)
                    report_mismatch("out_of_range", seen_result.far, want_result.far);
                if (seen_result.present !== want_result.present)
                    report_mismatch("hand_present", seen_result.present, want_result.present);
                if (seen_result.pos !== want_result.pos)
                    report_mismatch("position_byte", seen_result.pos, want_result.pos);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
            || (cfg_valid && cfg_ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        err_count     = 0;
        hold_req      = 0;
        idle_on       = 1'b1;
        quiet_cycles  = 0;
        awaiting_fall = 1'b0;
        rise_count    = '0;
        width_count   = '0;
        cur_range     = '0;
        good_range    = '0;
        far_now       = 1'b0;
        absent_count  = '0;
        present_now   = 1'b1;
        limit_reg     = 14'd500;
        period_reg    = PERIOD_RESET;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        capture_value <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_RANGE_LIMIT;
        cfg_data      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_config_extremes();
        test_period_lowered();
        test_random_pulses(250, 14'h3fff, 8'd255, 1'b1);
        test_random_pulses(250, 14'd0, 8'd0, 1'b1);
        test_random_pulses(250, 14'($urandom), 8'($urandom), 1'b1);
        test_random_pulses(250, 14'($urandom_range(100, 900)), 8'($urandom_range(0, 5)), 1'b0);
        test_random_pulses(250, 14'd500, 8'd3, 1'b1);
        test_random_pulses(250, 14'($urandom_range(1, 2000)), 8'($urandom_range(0, 10)), 1'b1);
        test_stall_fill();
        test_steady_flow();
        drain();

        if (pending_results.size() != 0)
        begin
            report_mismatch("results never delivered", 0, pending_results.size());
        end
        if (err_count == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
